[rtl/msp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and defaults for the multi-stack shared pool.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int DATA_W = 32;

  localparam int NUM_STACKS_DEF = 4;
  localparam int POOL_DEPTH_DEF = 16;

  typedef logic [1:0]               kind_t;
  typedef logic [1:0]               stat_t;
  typedef logic [1:0]               sid_t;
  typedef logic signed [DATA_W-1:0] word_t;

  localparam kind_t KIND_PUSH = 2'd0;
  localparam kind_t KIND_POP  = 2'd1;
  localparam kind_t KIND_PEEK = 2'd2;

  localparam stat_t STAT_OK        = 2'd0;
  localparam stat_t STAT_OVERFLOW  = 2'd1;
  localparam stat_t STAT_UNDERFLOW = 2'd2;

  localparam word_t MOST_NEG = 32'sh8000_0000;

endpackage
`default_nettype wire

[rtl/msp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msp_req_if / msp_rsp_if
// Request and result channels of the multi-stack shared pool.
// ----------------------------------------------------------------------------
interface msp_req_if;
  import msp_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  sid_t  stack_id;
  word_t data_in;

  modport source (output valid, kind, stack_id, data_in, input ready);
  modport sink   (input valid, kind, stack_id, data_in, output ready);
endinterface

interface msp_rsp_if;
  import msp_pkg::*;

  logic  valid;
  logic  ready;
  word_t data_out;
  stat_t status;
  logic  stack_empty;
  logic  store_full;

  modport source (output valid, data_out, status, stack_empty, store_full, input ready);
  modport sink   (input valid, data_out, status, stack_empty, store_full, output ready);
endinterface
`default_nettype wire

[rtl/msp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no new read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/multi_stack_shared_pool.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// Several LIFO stacks linked through one slot pool with a free list.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-----------------------------------------
//  in_ch    | in  | valid/ready  | kind, stack_id, data_in
//  out_ch   | out | valid/ready  | data_out, status, stack_empty, store_full
//
//  An item is accepted in ST_IDLE, which reads the data and link RAMs, and
//  written back in ST_EXEC, which modifies heads and writes the RAMs; the
//  registered RAM read sets this split. No new item is taken until the
//  last one is written back. Reset needs no clearing pass over the link
//  RAM, since a fill count marks slots never written, which read as their
//  initial link. A result held on out_ch stalls the write-back until taken.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool #(
  parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int POOL_DEPTH = msp_pkg::POOL_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  msp_req_if.sink   in_ch,
  msp_rsp_if.source out_ch
);
  import msp_pkg::*;

  localparam int AW    = $clog2(POOL_DEPTH);
  localparam int LW    = $clog2(POOL_DEPTH + 1);
  localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;

  logic [LW-1:0] head_r [NUM_STACKS];
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] fill_r, fill_nxt;

  // item held between accept and write-back
  kind_t            kind_r;
  logic [SID_W-1:0] sid_r;
  logic             vid_r;
  word_t            word_r;
  logic [LW-1:0]    top_r;
  logic [AW-1:0]    lraddr_r;

  logic          out_valid_r;
  word_t         out_data_r;
  stat_t         out_stat_r;
  logic          out_empty_r;
  logic          out_full_r;

  // accept side
  logic             in_fire;
  logic             in_vid;
  logic [SID_W-1:0] in_sid;
  logic [LW-1:0]    in_top;
  logic [AW-1:0]    in_lraddr;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_vid      = int'(in_ch.stack_id) < NUM_STACKS;
  assign in_sid      = SID_W'(in_ch.stack_id);
  assign in_top      = in_vid ? head_r[in_sid] : NULL_LINK;
  assign in_lraddr   = (in_ch.kind == KIND_PUSH) ? free_head_r[AW-1:0] : in_top[AW-1:0];

  // RAMs
  logic             link_we, data_we;
  logic [AW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata, link_rdata, link_eff;
  logic [DATA_W-1:0] data_rdata;

  msp_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (in_fire),
    .raddr (in_lraddr),
    .rdata (link_rdata)
  );

  msp_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (free_head_r[AW-1:0]),
    .wdata (word_r),
    .re    (in_fire),
    .raddr (in_top[AW-1:0]),
    .rdata (data_rdata)
  );

  // a slot at the fill mark was never written: it still links to the next slot
  assign link_eff = (LW'(lraddr_r) == fill_r) ? LW'(lraddr_r) + LW'(1) : link_rdata;

  // write-back cycle
  logic          done;
  logic          is_read, push_ok, top_ok;
  logic [LW-1:0] head_after;
  word_t         dout;
  stat_t         stat;

  always_comb begin
    done          = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
    is_read       = (kind_r == KIND_POP) || (kind_r == KIND_PEEK);
    push_ok       = (kind_r == KIND_PUSH) && vid_r && (free_head_r < NULL_LINK);
    top_ok        = vid_r && (top_r < NULL_LINK);
    head_after    = top_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    link_we       = 1'b0;
    data_we       = 1'b0;
    link_waddr    = free_head_r[AW-1:0];
    link_wdata    = top_r;
    dout          = '0;
    stat          = STAT_OK;

    if (kind_r == KIND_PUSH) begin
      if (push_ok) begin
        head_after    = free_head_r;
        free_head_nxt = link_eff;
        link_we       = done;
        data_we       = done;
        if (free_head_r == fill_r) begin
          fill_nxt = fill_r + LW'(1);
        end
      end else begin
        stat = STAT_OVERFLOW;
      end
    end else if (is_read) begin
      if (top_ok) begin
        dout = word_t'(data_rdata);
        if (kind_r == KIND_POP) begin
          head_after    = link_eff;
          free_head_nxt = top_r;
          link_we       = done;
          link_waddr    = top_r[AW-1:0];
          link_wdata    = free_head_r;
        end
      end else begin
        stat = STAT_UNDERFLOW;
        dout = MOST_NEG;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (done)    state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_r[i] <= NULL_LINK;
      end
    end else begin
      state_r <= state_nxt;
      if (done) begin
        free_head_r <= free_head_nxt;
        fill_r      <= fill_nxt;
        if (vid_r) begin
          head_r[sid_r] <= head_after;
        end
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_ch.kind;
      sid_r    <= in_sid;
      vid_r    <= in_vid;
      word_r   <= in_ch.data_in;
      top_r    <= in_top;
      lraddr_r <= in_lraddr;
    end
    if (done) begin
      out_data_r  <= dout;
      out_stat_r  <= stat;
      out_empty_r <= !(vid_r && (head_after < NULL_LINK));
      out_full_r  <= !(free_head_nxt < NULL_LINK);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.stack_empty = out_empty_r;
  assign out_ch.store_full  = out_full_r;

endmodule
`default_nettype wire

[tb/msp_pool_sb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msp_pool_sb_pkg
// Result predictor and scoreboard for the multi-stack shared pool. It keeps
// its own copy of the slot links, stack tops and free list, and it predicts
// each result from the requests in the order they were accepted.
// ----------------------------------------------------------------------------
package msp_pool_sb_pkg;
  import msp_pkg::*;

  localparam int NSTK  = NUM_STACKS_DEF;
  localparam int NSLOT = POOL_DEPTH_DEF;
  localparam int NIL   = NSLOT;

  // Kind code the block ignores
  localparam kind_t KIND_UNUSED = 2'd3;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    word_t data_out;
    stat_t status;
    logic  stack_empty;
    logic  store_full;
  } pool_result_t;

  class pool_scoreboard;
    word_t        slot_word [NSLOT];
    int           slot_next [NSLOT];
    int           stack_top [NSTK];
    int           free_top;
    int           live;
    pool_result_t result_q [$];
    int           errors;
    int           n_checked;
    int           n_overflow;
    int           n_underflow;
    int           n_ignored;
    int           n_full;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        slot_word[i] = '0;
        slot_next[i] = i + 1;  // last slot lands on NIL
      end
      for (int i = 0; i < NSTK; i++) begin
        stack_top[i] = NIL;
      end
      free_top    = 0;
      live        = 0;
      errors      = 0;
      n_checked   = 0;
      n_overflow  = 0;
      n_underflow = 0;
      n_ignored   = 0;
      n_full      = 0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function int used();
      return live;
    endfunction

    // Apply one accepted request to the shadow pool and queue its result
    function void note_request(kind_t kind, sid_t sid, word_t word);
      pool_result_t r;
      bit           id_ok;
      int           top;
      int           s;
      r     = '0;
      id_ok = int'(sid) < NSTK;
      top   = id_ok ? stack_top[sid] : NIL;
      case (kind)
        KIND_PUSH: begin
          if (!id_ok || free_top == NIL) begin
            r.status = STAT_OVERFLOW;
            n_overflow++;
          end else begin
            s              = free_top;
            free_top       = slot_next[s];
            slot_next[s]   = top;
            stack_top[sid] = s;
            slot_word[s]   = word;
            live++;
          end
        end
        KIND_POP, KIND_PEEK: begin
          if (!id_ok || top == NIL) begin
            r.status   = STAT_UNDERFLOW;
            r.data_out = MOST_NEG;
            n_underflow++;
          end else begin
            r.data_out = slot_word[top];
            if (kind == KIND_POP) begin
              stack_top[sid] = slot_next[top];
              slot_next[top] = free_top;
              free_top       = top;
              live--;
            end
          end
        end
        default: n_ignored++;
      endcase
      r.stack_empty = !id_ok || stack_top[sid] == NIL;
      r.store_full  = free_top == NIL;
      if (r.store_full) n_full++;
      result_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(pool_result_t got);
      pool_result_t want;
      if (result_q.size() == 0) begin
        report($sformatf("result with nothing pending: data_out %0d status %0d",
                         got.data_out, got.status));
        return;
      end
      want = result_q.pop_front();
      n_checked++;
      if (got.data_out !== want.data_out)
        report($sformatf("result %0d data_out %0d, want %0d",
                         n_checked, got.data_out, want.data_out));
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d",
                         n_checked, got.status, want.status));
      if (got.stack_empty !== want.stack_empty)
        report($sformatf("result %0d stack_empty %0b, want %0b",
                         n_checked, got.stack_empty, want.stack_empty));
      if (got.store_full !== want.store_full)
        report($sformatf("result %0d store_full %0b, want %0b",
                         n_checked, got.store_full, want.store_full));
    endtask
  endclass

endpackage

[tb/multi_stack_shared_pool_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_tb
// Drives push, pop, peek and ignored requests into the shared-pool stacks,
// first a directed fill-to-overflow pass, then randomized fill and drain
// phases with random idling on both channels, and checks every result field
// against a scoreboard that tracks the pool state.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_tb;
  import msp_pkg::*;
  import msp_pool_sb_pkg::*;

  localparam int N_RANDOM = 500;

  logic           clk;
  logic           rst_n;
  bit             calm;
  int             n_sent;
  pool_scoreboard sb;

  msp_req_if in_ch ();
  msp_rsp_if out_ch ();

  multi_stack_shared_pool u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("timeout with %0d results still pending", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side backpressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.data_out, out_ch.status, out_ch.stack_empty,
                       out_ch.store_full});
    end
  end

  task send_op(kind_t kind, sid_t sid, word_t word);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.stack_id <= sid;
    in_ch.data_in  <= word;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(kind, sid, word);
    n_sent++;
  endtask

  function word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return MOST_NEG;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task run_directed();
    send_op(KIND_POP, 2'd0, pick_word());
    send_op(KIND_PEEK, 2'd3, pick_word());
    send_op(KIND_UNUSED, 2'd1, pick_word());
    // Fill the whole pool, spreading slots over all stacks
    for (int i = 0; i < NSLOT; i++) begin
      case (i % 4)
        0:       send_op(KIND_PUSH, sid_t'(i % NSTK), MOST_NEG);
        1:       send_op(KIND_PUSH, sid_t'(i % NSTK), 32'sh7fff_ffff);
        2:       send_op(KIND_PUSH, sid_t'(i % NSTK), '0);
        default: send_op(KIND_PUSH, sid_t'(i % NSTK), -1);
      endcase
    end
    send_op(KIND_PUSH, 2'd2, 32'sh5a5a_a5a5);
    send_op(KIND_PEEK, 2'd1, pick_word());
    send_op(KIND_UNUSED, 2'd2, pick_word());
    send_op(KIND_POP, 2'd0, pick_word());
    send_op(KIND_POP, 2'd3, pick_word());
  endtask

  // Alternate fill and drain phases so the pool swings between empty and full
  task run_random(int count);
    bit    filling;
    sid_t  fav;
    sid_t  sid;
    kind_t k;
    int    roll;
    filling = 1'b1;
    fav     = '0;
    for (int i = 0; i < count; i++) begin
      calm = (i >= 150 && i < 300);
      if (filling && sb.used() == NSLOT && $urandom_range(0, 3) == 0)
        filling = 1'b0;
      else if (!filling && sb.used() == 0 && $urandom_range(0, 3) == 0)
        filling = 1'b1;
      else if ($urandom_range(0, 39) == 0)
        filling = !filling;
      if ($urandom_range(0, 19) == 0) fav = sid_t'($urandom_range(0, NSTK - 1));
      sid  = $urandom_range(0, 1) ? fav : sid_t'($urandom_range(0, NSTK - 1));
      roll = $urandom_range(0, 99);
      if (roll < 3)
        k = KIND_UNUSED;
      else if (roll < (filling ? 65 : 25))
        k = KIND_PUSH;
      else if (roll < (filling ? 85 : 80))
        k = KIND_POP;
      else
        k = KIND_PEEK;
      send_op(k, sid, pick_word());
    end
    calm = 1'b0;
  endtask

  initial begin
    sb     = new();
    calm   = 1'b0;
    n_sent = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_PUSH;
    in_ch.stack_id <= '0;
    in_ch.data_in  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(N_RANDOM);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests, checked %0d results across %0d stacks of a %0d-slot pool.",
             n_sent, sb.n_checked, NSTK, NSLOT);
    $display("Saw %0d overflows, %0d underflows, %0d ignored codes, pool full %0d times.",
             sb.n_overflow, sb.n_underflow, sb.n_ignored, sb.n_full);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
